// ----- hdl/stpa_pkg.sv -----
package stpa_pkg;

    localparam int MAX_LOOKAHEAD = 31;
    localparam int SAMPLE_BITS   = 16;
    localparam int DEPTH         = MAX_LOOKAHEAD + 1;
    localparam int PTR_BITS      = $clog2(DEPTH);
    localparam int FILL_BITS     = PTR_BITS + 1;
    localparam int MAG_BITS      = SAMPLE_BITS;
    localparam int ENV_BITS      = SAMPLE_BITS + 8;
    localparam int THR_BITS      = ENV_BITS + 16;
    localparam int STR_BITS      = 24;
    localparam int NUM_BITS      = MAG_BITS + 24;
    localparam logic [STR_BITS-1:0] STRENGTH_CAP = 24'd8388608;

    localparam logic [2:0] REG_MIN_LEVEL   = 3'd0;
    localparam logic [2:0] REG_SENSITIVITY = 3'd1;
    localparam logic [2:0] REG_MIN_SPACING = 3'd2;
    localparam logic [2:0] REG_LOOKAHEAD   = 3'd3;
    localparam logic [2:0] REG_ATTACK      = 3'd4;
    localparam logic [2:0] REG_RELEASE     = 3'd5;
    localparam logic [2:0] REG_STRIDE      = 3'd6;

    localparam logic KIND_RECORD    = 1'b0;
    localparam logic KIND_TRANSIENT = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic push;       // load frame into delay line and bucket
        logic eval_start; // latch oldest frame, compute threshold
        logic scan_step;  // compare one lookahead entry
        logic div_start;
        logic div_step;
        logic env_mult;   // form envelope delta product
        logic eval_done;  // commit envelope, pop frame
        logic emit_trans;
        logic emit_rec;
        logic clear;      // end of asset
    } stpa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic eval_more;  // oldest frame needs evaluation now
        logic trigger;    // evaluated frame fires
        logic scan_done;
        logic div_done;
        logic rec_due;
        logic last;
    } stpa_stat_t;

endpackage

// ----- hdl/stpa_datapath.sv -----
module stpa_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_index,
    input  logic [23:0]                     cfg_data,
    input  logic signed [15:0]              left_sample,
    input  logic signed [15:0]              right_sample,
    input  logic                            last_frame,
    input  stpa_pkg::stpa_cmd_t             cmd,
    output stpa_pkg::stpa_stat_t            stat,
    output logic                            res_kind,
    output logic [31:0]                     res_position,
    output logic signed [15:0]              res_min,
    output logic signed [15:0]              res_max,
    output logic [23:0]                     res_strength
);
    import stpa_pkg::*;

    logic [15:0] min_level_reg, sensitivity_reg, attack_reg, release_reg;
    logic [23:0] min_spacing_reg, stride_reg;
    logic [4:0]  lookahead_reg;

    logic [MAG_BITS-1:0]  mem [DEPTH];
    logic [PTR_BITS-1:0]  head_reg;
    logic [FILL_BITS-1:0] fill_reg;
    logic [31:0]          frame_reg, record_reg;
    logic [ENV_BITS-1:0]  env_reg;
    logic [MAG_BITS-1:0]  prev_reg;
    logic [32:0]          next_allowed_reg;
    logic signed [15:0]   bmin_reg, bmax_reg;
    logic [23:0]          bcount_reg;
    logic                 last_reg;

    logic [MAG_BITS-1:0]  m_reg, pk_reg;
    logic [PTR_BITS-1:0]  pf_reg, k_reg, win_reg;
    logic [THR_BITS-1:0]  thr_reg;
    logic                 trig_reg;
    logic [MAG_BITS-1:0]  rd_reg;
    logic [NUM_BITS-1:0]  rem_reg, quo_reg;
    logic [5:0]           dcnt_reg;
    logic [ENV_BITS+16:0] prod_reg;
    logic                 up_reg;

    // magnitude of the frame at the input
    logic [16:0] al, ar;
    logic [MAG_BITS-1:0] mag_in;
    assign al = left_sample[15] ? 17'(-$signed({left_sample[15], left_sample}))
                                : {1'b0, left_sample};
    assign ar = right_sample[15] ? 17'(-$signed({right_sample[15], right_sample}))
                                 : {1'b0, right_sample};
    assign mag_in = (al > ar) ? al[15:0] : ar[15:0];

    logic [FILL_BITS-1:0] la;
    assign la = FILL_BITS'(lookahead_reg);

    logic [FILL_BITS-1:0] w;
    assign w = ((fill_reg - 1'b1) > la) ? la : (fill_reg - 1'b1);

    logic [23:0] stride, spacing;
    assign stride  = (stride_reg == 24'd0) ? 24'd1 : stride_reg;
    assign spacing = (min_spacing_reg == 24'd0) ? 24'd1 : min_spacing_reg;

    assign stat.eval_more = (fill_reg != '0) && (last_reg || fill_reg > la);
    assign stat.trigger   = trig_reg;
    assign stat.scan_done = (k_reg == win_reg);
    assign stat.div_done  = (dcnt_reg == 6'd0);
    assign stat.rec_due   = (bcount_reg >= stride) || last_reg;
    assign stat.last      = last_reg;

    logic [THR_BITS-1:0] et, lt, thr_c, den;
    assign et    = THR_BITS'(env_reg * sensitivity_reg);
    assign lt    = THR_BITS'({min_level_reg, 16'd0});
    assign thr_c = (et > lt) ? et : lt;
    assign den   = (thr_reg < THR_BITS'(32'h10000)) ? THR_BITS'(32'h10000) : thr_reg;

    logic [ENV_BITS-1:0] m8, diff;
    assign m8   = {m_reg, 8'd0};
    assign diff = up_reg ? (m8 - env_reg) : (env_reg - m8);

    logic [NUM_BITS:0] rem_sh;
    logic              div_ge;
    assign rem_sh = {rem_reg, quo_reg[NUM_BITS-1]};
    assign div_ge = (rem_sh >= {1'b0, den});

    logic [31:0] peak_pos;
    assign peak_pos = frame_reg + 32'(pf_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.push)
            mem[PTR_BITS'(head_reg + fill_reg[PTR_BITS-1:0])] <= mag_in;
        rd_reg <= mem[PTR_BITS'(head_reg + k_reg + 1'b1)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_level_reg    <= '0;
            sensitivity_reg  <= 16'd256;
            min_spacing_reg  <= 24'd1;
            lookahead_reg    <= '0;
            attack_reg       <= '0;
            release_reg      <= '0;
            stride_reg       <= 24'd1;
            head_reg         <= '0;
            fill_reg         <= '0;
            frame_reg        <= '0;
            record_reg       <= '0;
            env_reg          <= '0;
            prev_reg         <= '0;
            next_allowed_reg <= '0;
            bmin_reg         <= 16'sh7fff;
            bmax_reg         <= 16'sh8000;
            bcount_reg       <= '0;
            last_reg         <= 1'b0;
            trig_reg         <= 1'b0;
            k_reg            <= '0;
            win_reg          <= '0;
            dcnt_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MIN_LEVEL:   min_level_reg   <= cfg_data[15:0];
                    REG_SENSITIVITY: sensitivity_reg <= cfg_data[15:0];
                    REG_MIN_SPACING: min_spacing_reg <= cfg_data;
                    REG_LOOKAHEAD:   lookahead_reg   <= cfg_data[4:0];
                    REG_ATTACK:      attack_reg      <= cfg_data[15:0];
                    REG_RELEASE:     release_reg     <= cfg_data[15:0];
                    REG_STRIDE:      stride_reg      <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.push)
            begin
                fill_reg   <= fill_reg + 1'b1;
                last_reg   <= last_frame;
                bcount_reg <= bcount_reg + 1'b1;
                bmin_reg   <= (left_sample < right_sample ? left_sample : right_sample)
                              < bmin_reg ? (left_sample < right_sample ? left_sample
                              : right_sample) : bmin_reg;
                bmax_reg   <= (left_sample > right_sample ? left_sample : right_sample)
                              > bmax_reg ? (left_sample > right_sample ? left_sample
                              : right_sample) : bmax_reg;
            end
            if (cmd.eval_start)
            begin
                m_reg    <= mem[head_reg];
                pk_reg   <= mem[head_reg];
                pf_reg   <= '0;
                k_reg    <= '0;
                win_reg  <= w[PTR_BITS-1:0];
                thr_reg  <= thr_c;
                trig_reg <= ({1'b0, frame_reg} >= next_allowed_reg)
                            && ({mem[head_reg], 16'd0} >= thr_c)
                            && (mem[head_reg] > prev_reg);
            end
            // while scanning, rd_reg holds entry k for any k above zero
            if (cmd.scan_step)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (cmd.div_start)
            begin
                if (rd_reg > pk_reg && k_reg != '0)
                begin
                    pk_reg <= rd_reg;
                    pf_reg <= k_reg;
                end
            end
            if (cmd.scan_step && k_reg != '0 && rd_reg > pk_reg)
            begin
                pk_reg <= rd_reg;
                pf_reg <= k_reg;
            end
            if (cmd.div_start)
            begin
                rem_reg  <= '0;
                quo_reg  <= {(rd_reg > pk_reg && k_reg != '0) ? rd_reg : pk_reg, 24'd0};
                dcnt_reg <= 6'(NUM_BITS);
            end
            if (cmd.div_step)
            begin
                if (div_ge)
                    rem_reg <= NUM_BITS'(rem_sh - {1'b0, den});
                else
                    rem_reg <= rem_sh[NUM_BITS-1:0];
                quo_reg  <= {quo_reg[NUM_BITS-2:0], div_ge};
                dcnt_reg <= dcnt_reg - 1'b1;
            end
            if (cmd.emit_trans)
            begin
                if ({pk_reg, 8'd0} > env_reg)
                    env_reg <= {pk_reg, 8'd0};
                next_allowed_reg <= {1'b0, peak_pos} + {9'd0, spacing};
            end
            if (cmd.env_mult)
            begin
                up_reg <= m8 > env_reg;
            end
            if (cmd.eval_done)
            begin
                if (up_reg)
                    env_reg <= env_reg + ENV_BITS'(prod_reg >> 16);
                else
                    env_reg <= env_reg - ENV_BITS'(prod_reg >> 16);
                prev_reg  <= m_reg;
                head_reg  <= head_reg + 1'b1;
                fill_reg  <= fill_reg - 1'b1;
                frame_reg <= frame_reg + 32'd1;
                trig_reg  <= 1'b0;
            end
            if (cmd.clear)
            begin
                head_reg         <= '0;
                fill_reg         <= '0;
                frame_reg        <= '0;
                record_reg       <= '0;
                env_reg          <= '0;
                prev_reg         <= '0;
                next_allowed_reg <= '0;
                bmin_reg         <= 16'sh7fff;
                bmax_reg         <= 16'sh8000;
                bcount_reg       <= '0;
                last_reg         <= 1'b0;
            end
            else if (cmd.emit_rec)
            begin
                record_reg <= record_reg + 32'd1;
                bmin_reg   <= 16'sh7fff;
                bmax_reg   <= 16'sh8000;
                bcount_reg <= '0;
            end
        end
    end

    // envelope delta product, registered in the cycle after the direction flag
    always_ff @(posedge clk)
    begin
        prod_reg <= (ENV_BITS+17)'(diff * (up_reg ? attack_reg : release_reg));
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.emit_trans)
        begin
            res_kind     <= KIND_TRANSIENT;
            res_position <= peak_pos;
            res_min      <= '0;
            res_max      <= '0;
            res_strength <= (quo_reg > NUM_BITS'(STRENGTH_CAP)) ? STRENGTH_CAP
                                                                 : quo_reg[23:0];
        end
        else if (cmd.emit_rec)
        begin
            res_kind     <= KIND_RECORD;
            res_position <= record_reg;
            res_min      <= bmin_reg;
            res_max      <= bmax_reg;
            res_strength <= '0;
        end
    end
endmodule

// ----- hdl/stpa_ctrl.sv -----
module stpa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_last,
    input  stpa_pkg::stpa_stat_t stat,
    output stpa_pkg::stpa_cmd_t  cmd
);
    import stpa_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_EVAL  = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_WAITT = 4'd5;
    localparam logic [3:0] S_ENV   = 4'd6;
    localparam logic [3:0] S_ENV2  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;
    localparam logic [3:0] S_REC   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       olast_reg, olast_next;
    logic       hold_reg, hold_next;
    logic       busy;

    assign busy      = valid_reg && !out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = valid_reg;
    assign out_last  = olast_reg;

    // A transient sits in the result register unpresented (hold_reg) until
    // the next result or the end of the request tells whether it is the last.
    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg && !out_ready;
        olast_next = olast_reg;
        hold_next  = hold_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_CHECK;
                end
            S_CHECK:
                if (stat.eval_more)
                begin
                    cmd.eval_start = 1'b1;
                    state_next     = S_EVAL;
                end
                else if (stat.rec_due)
                    state_next = S_REC;
                else
                begin
                    if (hold_reg)
                    begin
                        valid_next = 1'b1;
                        olast_next = 1'b1;
                        hold_next  = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            S_EVAL:
                state_next = stat.trigger ? S_SCAN : S_ENV;
            S_SCAN:
                if (stat.scan_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                    cmd.scan_step = 1'b1;
            S_DIV:
                if (stat.div_done)
                    state_next = S_WAITT;
                else
                    cmd.div_step = 1'b1;
            S_WAITT:
                if (hold_reg)
                begin
                    valid_next = 1'b1;
                    olast_next = 1'b0;
                    hold_next  = 1'b0;
                end
                else if (!busy)
                begin
                    cmd.emit_trans = 1'b1;
                    hold_next      = 1'b1;
                    state_next     = S_ENV;
                end
            S_ENV:
            begin
                cmd.env_mult = 1'b1;
                state_next   = S_ENV2;
            end
            S_ENV2:
                state_next = S_DONE;
            S_DONE:
            begin
                cmd.eval_done = 1'b1;
                state_next    = S_CHECK;
            end
            S_REC:
                if (hold_reg)
                begin
                    valid_next = 1'b1;
                    olast_next = 1'b0;
                    hold_next  = 1'b0;
                end
                else if (!busy)
                begin
                    cmd.emit_rec = 1'b1;
                    cmd.clear    = stat.last;
                    valid_next   = 1'b1;
                    olast_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            olast_reg <= 1'b0;
            hold_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            olast_reg <= olast_next;
            hold_reg  <= hold_next;
        end
    end
endmodule

// ----- hdl/stereo_transient_peak_analyzer.sv -----
// channel   direction  handshake
// in        input      in_valid / in_ready
// out       output     out_valid / out_ready
// cfg       input      cfg_we, write only
// A request pushes one frame, evaluates each frame that is due and may emit a
// min/max record; a transient adds a lookahead scan, a divider (one quotient
// bit per cycle) and its output. The divider dominates.
// Reset clears all stream state; the delay memory needs no clearing.
// A stalled output holds the controller in place where it must emit a result;
// a transient is held back until its last flag is known.
module stereo_transient_peak_analyzer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] left_sample,
    input  logic signed [15:0] right_sample,
    input  logic               last_frame,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               record_kind,
    output logic [31:0]        position,
    output logic signed [15:0] peak_minimum,
    output logic signed [15:0] peak_maximum,
    output logic [23:0]        strength,
    output logic               last_result
);
    import stpa_pkg::*;

    stpa_cmd_t  cmd;
    stpa_stat_t stat;

    stpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_last  (last_result),
        .stat      (stat),
        .cmd       (cmd)
    );

    stpa_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .last_frame   (last_frame),
        .cmd          (cmd),
        .stat         (stat),
        .res_kind     (record_kind),
        .res_position (position),
        .res_min      (peak_minimum),
        .res_max      (peak_maximum),
        .res_strength (strength)
    );
endmodule
